FILE: rtl/core/sce_pkg.sv
// Shared constants, codes and types of the sandpile cell event engine.
`timescale 1ns / 1ps

package sce_pkg;

   // Grid and store sizing
   localparam int MAX_SIDE    = 256;
   localparam int HEIGHT_BITS = 24;

   // Fixed field widths
   localparam int CELL_W     = 16;
   localparam int SIDE_W     = 9;
   localparam int THR_W      = 16;
   localparam int TIME_W     = 32;
   localparam int HFIELD_W   = 24;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int AREA_W     = 2 * SIDE_W;

   // Only cells below 2^CELL_W can ever be addressed
   localparam int STORE_DEPTH = (MAX_SIDE * MAX_SIDE > (2 ** CELL_W)) ?
                                (2 ** CELL_W) : (MAX_SIDE * MAX_SIDE);
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

   // Grains removed by a cell's own topple, added by a neighbor's
   localparam int SELF_DROP    = 4;
   localparam int NEIGHBOR_ADD = 1;

   // Remainder unit: quotient bits resolved per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = CELL_W / DIV_STEP;
   localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_DELIVER = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INIT    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

   // Result kinds
   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd2;

   // Order of the five emitted events
   typedef logic [2:0] sce_emit_idx_type;
   localparam sce_emit_idx_type EMIT_SELF  = 3'd0;
   localparam sce_emit_idx_type EMIT_UP    = 3'd1;
   localparam sce_emit_idx_type EMIT_RIGHT = 3'd2;
   localparam sce_emit_idx_type EMIT_DOWN  = 3'd3;
   localparam sce_emit_idx_type EMIT_LEFT  = 3'd4;

   // Position of the toppling cell on the torus
   typedef struct packed {
      logic [CELL_W-1:0] cell_idx;
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] w;
      logic [AREA_W-1:0] area;
   } sce_geom_type;

endpackage

FILE: rtl/core/sandpile_cell_event_engine.sv
// Top level of the sandpile cell event engine: store sweep, update sequencer, result register.
`timescale 1ns / 1ps

// Keeps one grain height per cell of a grid_width x grid_height torus in a
// synchronous RAM and serves one request word at a time. After reset the RAM
// is swept to zero, one entry per cycle, all STORE_DEPTH of them (65536 at the
// default size); req_ready stays low during the sweep while csr writes are
// taken. A request whose cell is outside the grid, or with the unused type
// code, is dropped in its accept cycle. Otherwise the height is read, updated
// and written back the next cycle. A delivery or initialize that stays below
// the threshold returns no word; a read returns one report word.
// A topple returns five event words (self, up, right, down, left): the
// remainder unit that finds the cell's column runs alongside the RAM read,
// then one word leaves per cycle while the result side keeps taking them.
// The result register decouples the sides, so the next request is accepted
// while the final word of the previous one still waits. Grid sizes of 0 act
// as 1, above MAX_SIDE as MAX_SIDE.
module sandpile_cell_event_engine import sce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_req_type,
   input  logic [CELL_W-1:0]     req_target_cell,
   input  logic                  req_is_self,
   input  logic [TIME_W-1:0]     req_event_time,
   input  logic [HFIELD_W-1:0]   req_load_height,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_out_kind,
   output logic [CELL_W-1:0]     rsp_dest_cell,
   output logic                  rsp_dest_is_self,
   output logic [TIME_W-1:0]     rsp_out_time,
   output logic [HFIELD_W-1:0]   rsp_cell_height,
   output logic                  rsp_last
);

   // Sequencer states
   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [STORE_AW-1:0]    clr_addr_ff;

   // Configuration
   logic [SIDE_W-1:0]      grid_width_ff;
   logic [SIDE_W-1:0]      grid_height_ff;
   logic [THR_W-1:0]       thr_ff;
   logic [SIDE_W-1:0]      w_eff;
   logic [SIDE_W-1:0]      h_eff;
   logic [AREA_W-1:0]      area_cells;

   // Request in flight
   logic [REQ_W-1:0]       type_ff;
   logic [CELL_W-1:0]      cell_ff;
   logic                   self_ff;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [HFIELD_W-1:0]    load_ff;
   logic [HEIGHT_BITS-1:0] h_ff;
   logic [HEIGHT_BITS-1:0] h_old;
   logic [HEIGHT_BITS-1:0] h_new;
   logic                   topple;
   sce_emit_idx_type       emit_idx_ff, emit_idx_in;

   // Handshake and datapath controls
   logic                   req_fire;
   logic                   req_take;
   logic                   report;
   logic                   slot_free;
   logic                   emit_go;
   logic                   ram_we;
   logic [STORE_AW-1:0]    ram_waddr;
   logic [HEIGHT_BITS-1:0] ram_wdata;
   logic                   div_done;
   logic [SIDE_W-1:0]      div_rem;
   sce_geom_type           geom;
   logic [CELL_W-1:0]      nbr_cell;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [CELL_W-1:0]      rsp_cell_ff, rsp_cell_in;
   logic                   rsp_self_ff, rsp_self_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;
   logic [HFIELD_W-1:0]    rsp_height_ff, rsp_height_in;
   logic                   rsp_last_ff, rsp_last_in;

   function automatic logic [TIME_W-1:0] req_time_next(input logic [TIME_W-1:0] t);
      return t + 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers; clamp the sides and form the cell count
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIDE_W'(256);
         grid_height_ff <= SIDE_W'(256);
         thr_ff         <= THR_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[SIDE_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[SIDE_W-1:0];
            CSR_THRESHOLD:   thr_ff         <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = SIDE_W'(1);
      end else if (32'(grid_width_ff) > MAX_SIDE) begin
         w_eff = SIDE_W'(MAX_SIDE);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_eff = SIDE_W'(1);
      end else if (32'(grid_height_ff) > MAX_SIDE) begin
         h_eff = SIDE_W'(MAX_SIDE);
      end else begin
         h_eff = grid_height_ff;
      end
   end

   // follow a register write at once, a request may arrive the next cycle
   assign area_cells = AREA_W'(w_eff) * AREA_W'(h_eff);

   // ---------------------------------------------------------------------
   // Accept: drop unknown types and cells outside the grid right away
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_take  = req_fire && (req_req_type != REQ_UNUSED) &&
                      (AREA_W'(req_target_cell) < area_cells);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= req_req_type;
         cell_ff <= req_target_cell;
         self_ff <= req_is_self;
         load_ff <= req_load_height;
      end
   end

   // ---------------------------------------------------------------------
   // Height store and column finder
   // ---------------------------------------------------------------------
   sce_height_ram #(
      .DEPTH (STORE_DEPTH),
      .AW    (STORE_AW),
      .DW    (HEIGHT_BITS)
   ) u_height_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_target_cell[STORE_AW-1:0]),
      .rd_data (h_old)
   );

   sce_rem_unit u_rem_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .dividend  (req_target_cell),
      .divisor   (w_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ---------------------------------------------------------------------
   // Update: modify the height read last cycle and write it back
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (type_ff)
         REQ_DELIVER: begin
            if (self_ff) begin
               h_new = (h_old >= HEIGHT_BITS'(SELF_DROP)) ?
                       h_old - HEIGHT_BITS'(SELF_DROP) : '0;
            end else begin
               h_new = (h_old == HEIGHT_MAX) ?
                       HEIGHT_MAX : h_old + HEIGHT_BITS'(NEIGHBOR_ADD);
            end
         end
         REQ_INIT: begin
            h_new = (33'(load_ff) > 33'(HEIGHT_MAX)) ?
                    HEIGHT_MAX : HEIGHT_BITS'(load_ff);
         end
         default: begin
            h_new = h_old;
         end
      endcase
   end

   assign topple  = (33'(h_new) >= 33'(thr_ff));
   assign time_in = (type_ff == REQ_INIT) ? TIME_W'(1) : req_time_next(time_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         time_ff <= req_event_time;
      end else if (state_ff == ST_UPDATE) begin
         time_ff <= time_in;
      end
      if (state_ff == ST_UPDATE) begin
         h_ff <= h_new;
      end
   end

   // Write port: the reset sweep, or the write-back of an update
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = (state_ff == ST_UPDATE) && (type_ff != REQ_READ);
         ram_waddr = cell_ff[STORE_AW-1:0];
         ram_wdata = h_new;
      end
   end

   // ---------------------------------------------------------------------
   // Emit: one word per cycle while the result side is not stalling, into the result register
   // ---------------------------------------------------------------------
   assign geom.cell_idx = cell_ff;
   assign geom.x        = div_rem;
   assign geom.w        = w_eff;
   assign geom.area     = area_cells;

   sce_nbr_addr u_nbr_addr (
      .geom      (geom),
      .emit_idx  (emit_idx_ff),
      .dest_cell (nbr_cell)
   );

   assign report    = (type_ff == REQ_READ);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_go   = (state_ff == ST_EMIT) && slot_free && (report || div_done);

   always_comb begin
      rsp_kind_in   = report ? KIND_REPORT : KIND_EVENT;
      rsp_cell_in   = report ? cell_ff : nbr_cell;
      rsp_self_in   = !report && (emit_idx_ff == EMIT_SELF);
      rsp_time_in   = report ? '0 : time_ff;
      rsp_height_in = HFIELD_W'(h_ff);
      rsp_last_in   = report || (emit_idx_ff == EMIT_LEFT);
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_cell_ff   <= rsp_cell_in;
         rsp_self_ff   <= rsp_self_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_height_ff <= rsp_height_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_kind_ff;
   assign rsp_dest_cell    = rsp_cell_ff;
   assign rsp_dest_is_self = rsp_self_ff;
   assign rsp_out_time     = rsp_time_ff;
   assign rsp_cell_height  = rsp_height_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      emit_idx_in = emit_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            emit_idx_in = EMIT_SELF;
            if (report || topple) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         emit_idx_ff <= EMIT_SELF;
      end else begin
         state_ff    <= state_in;
         emit_idx_ff <= emit_idx_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // a request read never races a store write
   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !ram_we)
      else $error("request accepted while the height store is written");

   // neighbor words need the column from the remainder unit
   a_event_needs_column: assert property (@(posedge clock) disable iff (reset)
      (emit_go && !report) |-> div_done)
      else $error("event word sent before the column was known");

   // the final word of a request returns the sequencer to idle
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit_go && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept working after the final word");

   // a word is never overwritten while the result side stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !emit_go)
      else $error("result register loaded while a word was waiting");
`endif

endmodule

FILE: rtl/core/sce_height_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sce_height_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sce_rem_unit.sv
// Multi-cycle remainder unit: cell index modulo grid width, several bits per cycle.
`timescale 1ns / 1ps

module sce_rem_unit import sce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CELL_W-1:0] dividend,
   input  logic [SIDE_W-1:0] divisor,
   output logic              done,
   output logic [SIDE_W-1:0] remainder
);

   logic [CELL_W-1:0]    dvd_ff, dvd_in;
   logic [SIDE_W-1:0]    dvs_ff;
   logic [SIDE_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // restoring steps on the partial remainder
   always_comb begin : rem_step
      logic [SIDE_W:0]   trial;
      logic [SIDE_W-1:0] r;
      logic [CELL_W-1:0] d;
      r = rem_ff;
      d = dvd_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {r, d[CELL_W-1]};
         d     = {d[CELL_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            r = SIDE_W'(trial - {1'b0, dvs_ff});
         end else begin
            r = trial[SIDE_W-1:0];
         end
      end
      rem_in = r;
      dvd_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/sce_nbr_addr.sv
// Torus neighbor address generator for the five events of a topple.
`timescale 1ns / 1ps

module sce_nbr_addr import sce_pkg::*; (
   input  sce_geom_type      geom,
   input  sce_emit_idx_type  emit_idx,
   output logic [CELL_W-1:0] dest_cell
);

   logic [AREA_W-1:0] c;
   logic [AREA_W-1:0] w;
   logic [AREA_W-1:0] x;
   logic [AREA_W-1:0] up_sum;
   logic [AREA_W-1:0] dest;

   assign c      = AREA_W'(geom.cell_idx);
   assign w      = AREA_W'(geom.w);
   assign x      = AREA_W'(geom.x);
   assign up_sum = c + w;

   always_comb begin
      unique case (emit_idx)
         EMIT_UP: begin
            dest = (up_sum >= geom.area) ? up_sum - geom.area : up_sum;
         end
         EMIT_RIGHT: begin
            dest = (x == w - 1'b1) ? c - x : c + 1'b1;
         end
         EMIT_DOWN: begin
            dest = (c < w) ? c + geom.area - w : c - w;
         end
         EMIT_LEFT: begin
            dest = (x == '0) ? c + w - 1'b1 : c - 1'b1;
         end
         default: begin
            dest = c;
         end
      endcase
   end

   assign dest_cell = CELL_W'(dest);

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the sandpile cell event engine.
`timescale 1ns / 1ps

module tb_top;
   import sce_pkg::*;

   // Idle cycles after the last result before a register write; covers a
   // request that is still being written back without any result
   localparam int SETTLE_CYCLES = 16;
   // Covers the post-reset store sweep plus the slowest legal run, with margin
   localparam int CYCLE_LIMIT   = 1000000;

   // One result word as the block should present it
   typedef struct packed {
      logic                kind;
      logic [CELL_W-1:0]   cell_idx;
      logic                is_own;
      logic [TIME_W-1:0]   stamp;
      logic [HFIELD_W-1:0] height;
      logic                last;
   } pile_word_type;

   // A grain event emitted by a topple, kept so it can be fed back in
   typedef struct packed {
      logic [CELL_W-1:0] cell_idx;
      logic              is_own;
      logic [TIME_W-1:0] stamp;
   } grain_event_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_req_type;
   logic [CELL_W-1:0]     req_target_cell;
   logic                  req_is_self;
   logic [TIME_W-1:0]     req_event_time;
   logic [HFIELD_W-1:0]   req_load_height;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_out_kind;
   logic [CELL_W-1:0]     rsp_dest_cell;
   logic                  rsp_dest_is_self;
   logic [TIME_W-1:0]     rsp_out_time;
   logic [HFIELD_W-1:0]   rsp_cell_height;
   logic                  rsp_last;

   // Predictor state: its own copy of the heights and the registers
   logic [HEIGHT_BITS-1:0] pile_height [STORE_DEPTH];
   logic [SIDE_W-1:0]      grid_width_q;
   logic [SIDE_W-1:0]      grid_height_q;
   logic [THR_W-1:0]       threshold_q;

   pile_word_type   expected_words [$];
   grain_event_type grain_backlog  [$];

   // Idling controls: quiet mode for the sender and result side, hold-off for the result side
   bit quiet_mode;
   int hold_off_cycles;

   int fail_count;
   int cycle_count;
   int requests_sent;
   int handled_count;
   int topple_count;
   int report_count;
   int dropped_count;
   int words_checked;
   int settings_used;

   sandpile_cell_event_engine dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_req_type     (req_req_type),
      .req_target_cell  (req_target_cell),
      .req_is_self      (req_is_self),
      .req_event_time   (req_event_time),
      .req_load_height  (req_load_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_dest_cell    (rsp_dest_cell),
      .rsp_dest_is_self (rsp_dest_is_self),
      .rsp_out_time     (rsp_out_time),
      .rsp_cell_height  (rsp_cell_height),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d words still expected",
                  $time, cycle_count, expected_words.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // Sides of 0 act as 1, sides above MAX_SIDE act as MAX_SIDE
   function automatic int unsigned effective_side(logic [SIDE_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_SIDE)
         return MAX_SIDE;
      return 32'(v);
   endfunction

   function automatic int unsigned grid_area();
      return effective_side(grid_width_q) * effective_side(grid_height_q);
   endfunction

   // Append at the tail of the queues
   function automatic void queue_word(pile_word_type word);
      expected_words.insert(expected_words.size(), word);
   endfunction

   function automatic void queue_grain(grain_event_type ev);
      grain_backlog.insert(grain_backlog.size(), ev);
   endfunction

   // Update the predicted heights for one accepted request word and queue the
   // result words it must produce: none, one height report, or five events.
   function automatic void apply_grain_request(logic [REQ_W-1:0] kind,
                                               logic [CELL_W-1:0] cell_idx,
                                               logic own,
                                               logic [TIME_W-1:0] stamp,
                                               logic [HFIELD_W-1:0] load);
      int unsigned w;
      int unsigned hg;
      int unsigned x;
      int unsigned y;
      int unsigned dest [5];
      logic [HEIGHT_BITS-1:0] h;
      logic [TIME_W-1:0] out_stamp;
      pile_word_type word;
      grain_event_type ev;

      w  = effective_side(grid_width_q);
      hg = effective_side(grid_height_q);
      requests_sent++;
      if (!(kind inside {REQ_DELIVER, REQ_INIT, REQ_READ}) || cell_idx >= w * hg) begin
         dropped_count++;
         return;
      end
      handled_count++;
      h = pile_height[cell_idx];

      if (kind == REQ_READ) begin
         word.kind     = KIND_REPORT;
         word.cell_idx = cell_idx;
         word.is_own   = 1'b0;
         word.stamp    = '0;
         word.height   = h;
         word.last     = 1'b1;
         queue_word(word);
         report_count++;
         return;
      end

      if (kind == REQ_INIT) begin
         h = (load > HEIGHT_MAX) ? HEIGHT_MAX : HEIGHT_BITS'(load);
         out_stamp = 1;
      end else begin
         if (own)
            h = (h >= SELF_DROP) ? HEIGHT_BITS'(h - SELF_DROP) : '0;
         else
            h = (h == HEIGHT_MAX) ? HEIGHT_MAX : HEIGHT_BITS'(h + NEIGHBOR_ADD);
         out_stamp = stamp + 1;
      end
      pile_height[cell_idx] = h;
      if (h < threshold_q)
         return;

      // Topple: own event first, then the four torus neighbors
      topple_count++;
      x = cell_idx % w;
      y = cell_idx / w;
      dest[EMIT_SELF]  = cell_idx;
      dest[EMIT_UP]    = x + ((y + 1) % hg) * w;
      dest[EMIT_RIGHT] = ((x + 1) % w) + y * w;
      dest[EMIT_DOWN]  = x + ((y + hg - 1) % hg) * w;
      dest[EMIT_LEFT]  = ((x + w - 1) % w) + y * w;
      for (int k = 0; k < 5; k++) begin
         word.kind     = KIND_EVENT;
         word.cell_idx = dest[k][CELL_W-1:0];
         word.is_own   = (k == EMIT_SELF);
         word.stamp    = out_stamp;
         word.height   = h;
         word.last     = (k == EMIT_LEFT);
         queue_word(word);
         ev.cell_idx = word.cell_idx;
         ev.is_own   = word.is_own;
         ev.stamp    = out_stamp;
         queue_grain(ev);
      end
      // Keep the feedback pool bounded; an unstable pile would grow it forever
      while (grain_backlog.size() > 200)
         void'(grain_backlog.pop_front());
   endfunction

   // Mostly back-to-back words, sometimes a short gap, rarely a long one; no gap in quiet mode
   function automatic int pick_gap();
      int roll;
      if (quiet_mode)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request word and hold it until accepted, then predict it
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic [CELL_W-1:0] cell_idx,
                               input logic own,
                               input logic [TIME_W-1:0] stamp,
                               input logic [HFIELD_W-1:0] load);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_req_type    = kind;
      req_target_cell = cell_idx;
      req_is_self     = own;
      req_event_time  = stamp;
      req_load_height = load;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_grain_request(kind, cell_idx, own, stamp, load);
   endtask

   // Drop valid and wait until every expected word has come back, then let
   // any silent request finish its write-back
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_GRID_WIDTH:  grid_width_q  = data[SIDE_W-1:0];
         CSR_GRID_HEIGHT: grid_height_q = data[SIDE_W-1:0];
         CSR_THRESHOLD:   threshold_q   = data[THR_W-1:0];
         default: ;
      endcase
      // Old events may point outside the new grid
      grain_backlog.delete();
      settings_used++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, seen);
         fail_count++;
      end
   endtask

   task automatic check_pile_word(input pile_word_type seen);
      pile_word_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word: expected none actual cell %h kind %b",
                  $time, seen.cell_idx, seen.kind);
         fail_count++;
         return;
      end
      want = expected_words.pop_front();
      compare_field("out_kind", want.kind, seen.kind);
      compare_field("dest_cell", want.cell_idx, seen.cell_idx);
      compare_field("dest_is_self", want.is_own, seen.is_own);
      compare_field("out_time", want.stamp, seen.stamp);
      compare_field("cell_height", want.height, seen.height);
      compare_field("last", want.last, seen.last);
      words_checked++;
   endtask

   // Result side: check every word taken at a rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_pile_word('{rsp_out_kind, rsp_dest_cell, rsp_dest_is_self,
                           rsp_out_time, rsp_cell_height, rsp_last});
   end

   // Result-side ready: random stalls, none in quiet mode, and a long
   // hold-off counted here when a test asks for one
   initial begin
      int stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready = 1'b0;
            repeat (hold_off_cycles - 1) @(negedge clock);
            hold_off_cycles = 0;
         end else if (stall_left != 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (quiet_mode || $urandom_range(0, 99) < 70) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready  = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   // Default 256 x 256 grid, threshold 4: reports, time wrap, saturation at
   // both ends, the unused code and the corner cells of the torus
   task automatic test_default_grid();
      send_request(REQ_READ, 16'd0, 1'b0, 32'h0, 24'h0);
      send_request(REQ_READ, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
      send_request(REQ_INIT, 16'd0, 1'b0, 32'h0, 24'd3);
      // 3 + 1 reaches the threshold; timestamp wraps to zero
      send_request(REQ_DELIVER, 16'd0, 1'b0, 32'hFFFF_FFFF, 24'h0);
      send_request(REQ_DELIVER, 16'd0, 1'b1, 32'd5, 24'h0);
      // Own topple on an empty cell saturates at zero
      send_request(REQ_DELIVER, 16'd0, 1'b1, 32'd6, 24'h0);
      send_request(REQ_INIT, 16'hFFFF, 1'b0, 32'h0, 24'hFF_FFFF);
      // Neighbor grain on a full cell saturates at the maximum
      send_request(REQ_DELIVER, 16'hFFFF, 1'b0, 32'h1234_5678, 24'h0);
      send_request(REQ_UNUSED, 16'd5, 1'b0, 32'h0, 24'h0);
      send_request(REQ_READ, 16'hFFFF, 1'b0, 32'h0, 24'h0);
      send_request(REQ_DELIVER, 16'hFFFF, 1'b1, 32'h8000_0000, 24'h0);
   endtask

   // Grid sides at and beyond their limits, upper write-data bits set
   task automatic test_grid_limits();
      write_register(CSR_GRID_WIDTH, 16'h0000);
      write_register(CSR_GRID_HEIGHT, 16'h0000);
      // 1 x 1 torus: every neighbor is the cell itself
      send_request(REQ_INIT, 16'd0, 1'b0, 32'h0, 24'd7);
      send_request(REQ_DELIVER, 16'd1, 1'b0, 32'h0, 24'h0);
      send_request(REQ_READ, 16'd1, 1'b0, 32'h0, 24'h0);
      // Oversized sides act as MAX_SIDE
      write_register(CSR_GRID_WIDTH, 16'hFFFF);
      write_register(CSR_GRID_HEIGHT, 16'h0101);
      send_request(REQ_READ, 16'hFFFF, 1'b0, 32'h0, 24'h0);
      write_register(CSR_GRID_WIDTH, 16'hFE03);
      write_register(CSR_GRID_HEIGHT, 16'h0002);
      send_request(REQ_INIT, 16'd5, 1'b0, 32'h0, 24'd4);
      send_request(REQ_DELIVER, 16'd6, 1'b0, 32'h0, 24'h0);
   endtask

   // Threshold of zero topples every update; the maximum needs a tall pile
   task automatic test_threshold_limits();
      write_register(CSR_GRID_WIDTH, 16'd8);
      write_register(CSR_GRID_HEIGHT, 16'd8);
      write_register(CSR_THRESHOLD, 16'h0000);
      send_request(REQ_DELIVER, 16'd9, 1'b1, 32'd100, 24'h0);
      send_request(REQ_READ, 16'd9, 1'b0, 32'h0, 24'h0);
      write_register(CSR_THRESHOLD, 16'hFFFF);
      send_request(REQ_INIT, 16'd10, 1'b0, 32'h0, 24'h00_FFFF);
      send_request(REQ_INIT, 16'd11, 1'b0, 32'h0, 24'h00_FFFE);
      send_request(REQ_DELIVER, 16'd11, 1'b0, 32'd7, 24'h0);
      write_register(CSR_THRESHOLD, 16'd1);
      send_request(REQ_DELIVER, 16'd12, 1'b0, 32'd3, 24'h0);
   endtask

   // Hold the result side off while the sender keeps offering toppling
   // initializations, so the block fills and must stall its input
   task automatic test_output_backpressure();
      write_register(CSR_GRID_WIDTH, 16'd4);
      write_register(CSR_GRID_HEIGHT, 16'd4);
      write_register(CSR_THRESHOLD, 16'd4);
      quiet_mode = 1'b1;
      hold_off_cycles = 200;
      for (int i = 0; i < 12; i++)
         send_request(REQ_INIT, CELL_W'($urandom_range(0, 15)), 1'b0, $urandom,
                      HFIELD_W'($urandom_range(4, 9)));
      quiet_mode = 1'b0;
   endtask

   // Any real request code, for words aimed outside the grid
   function automatic logic [REQ_W-1:0] REQ_TYPE_PICK();
      case ($urandom_range(0, 2))
         0:       return REQ_DELIVER;
         1:       return REQ_INIT;
         default: return REQ_READ;
      endcase
   endfunction

   // One random phase: mostly grain events fed back from earlier topples,
   // the rest fresh deliveries, loads, reads and words the block drops
   task automatic run_sandpile_phase(input int side_x, input int side_y,
                                     input int thr, input int count, input bit calm);
      int start;
      int roll;
      int unsigned area;
      logic [CELL_W-1:0] pick_cell;
      logic [TIME_W-1:0] stamp;
      logic [HFIELD_W-1:0] load;
      grain_event_type ev;

      write_register(CSR_GRID_WIDTH, CSR_DATA_W'(side_x));
      write_register(CSR_GRID_HEIGHT, CSR_DATA_W'(side_y));
      write_register(CSR_THRESHOLD, CSR_DATA_W'(thr));
      quiet_mode = calm;
      area  = grid_area();
      start = handled_count;
      while (handled_count - start < count) begin
         pick_cell = CELL_W'($urandom_range(0, area - 1));
         stamp = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : TIME_W'($urandom);
         load  = ($urandom_range(0, 1) == 0) ? HFIELD_W'($urandom_range(0, thr + 2))
                                             : HFIELD_W'($urandom_range(0, 24'hFF_FFFF));
         if (grain_backlog.size() != 0 && $urandom_range(0, 99) < 55) begin
            ev = grain_backlog.pop_front();
            send_request(REQ_DELIVER, ev.cell_idx, ev.is_own, ev.stamp, load);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45 || (roll >= 75 && roll < 88))
               send_request(REQ_DELIVER, pick_cell, $urandom_range(0, 3) == 0, stamp, load);
            else if (roll < 60)
               send_request(REQ_INIT, pick_cell, 1'($urandom_range(0, 1)), stamp, load);
            else if (roll < 75)
               send_request(REQ_READ, pick_cell, 1'($urandom_range(0, 1)), stamp, load);
            else if (roll < 96 && area < STORE_DEPTH)
               send_request(REQ_TYPE_PICK(), CELL_W'($urandom_range(area, 16'hFFFF)),
                            1'($urandom_range(0, 1)), stamp, load);
            else
               send_request(REQ_UNUSED, pick_cell, 1'($urandom_range(0, 1)), stamp, load);
         end
      end
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_sandpile();
      run_sandpile_phase(4, 4, 4, 50, 1'b0);
      run_sandpile_phase(3, 5, 4, 40, 1'b1);
      run_sandpile_phase(1, 7, 2, 35, 1'b0);
      run_sandpile_phase(7, 1, 3, 35, 1'b0);
      run_sandpile_phase(16, 16, 4, 40, 1'b0);
      run_sandpile_phase(256, 256, $urandom_range(1, 6), 40, 1'b0);
      run_sandpile_phase(5, 3, 1, 30, 1'b0);
   endtask

   initial begin
      // Drive every input to a known value before the first edge
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_GRID_WIDTH;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_req_type    = REQ_DELIVER;
      req_target_cell = '0;
      req_is_self     = 1'b0;
      req_event_time  = '0;
      req_load_height = '0;
      quiet_mode      = 1'b0;
      hold_off_cycles = 0;
      grid_width_q    = SIDE_W'(MAX_SIDE);
      grid_height_q   = SIDE_W'(MAX_SIDE);
      threshold_q     = THR_W'(4);
      for (int i = 0; i < STORE_DEPTH; i++)
         pile_height[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_grid();
      test_grid_limits();
      test_threshold_limits();
      test_output_backpressure();
      test_random_sandpile();

      wait_idle();
      $display("Covered %0d request words (%0d dropped) over %0d register writes,",
               requests_sent, dropped_count, settings_used);
      $display("with %0d topples and %0d height reports; %0d result words checked.",
               topple_count, report_count, words_checked);
      if (fail_count == 0 && expected_words.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
